/* rtl/u8d_pkg.sv */
// Package: types and constants shared by the UTF-8 stream decoder files.
package u8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 31;
  localparam int unsigned LenW  = 3;
  localparam int unsigned ContW = 6;

  localparam logic [ByteW-1:0] AsciiBit    = 8'h80;
  localparam logic [ByteW-1:0] PayloadMask = 8'h7f;
  localparam logic [ByteW-1:0] ContMask    = 8'h3f;
  localparam logic [LenW-1:0]  OneByte     = 3'd1;
  localparam logic [LenW-1:0]  MaxLen      = 3'd6;

  typedef struct packed {
    logic [CpW-1:0]  partial_value;
    logic [LenW-1:0] bytes_left;
    logic [LenW-1:0] sequence_length;
  } state_t;

  typedef struct packed {
    logic            valid;
    logic [CpW-1:0]  code_point;
    logic [LenW-1:0] seq_bytes;
    logic            malformed;
  } result_t;

endpackage

/* rtl/u8d_ifs.sv */
// Interfaces: byte input channel and code point output channel.
interface u8d_byte_if;
  logic                       valid;
  logic                       ready;
  logic [u8d_pkg::ByteW-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface u8d_code_if;
  logic                      valid;
  logic                      ready;
  logic [u8d_pkg::CpW-1:0]  code_point;
  logic [u8d_pkg::LenW-1:0] seq_bytes;
  logic                      malformed;

  modport source (output valid, output code_point, output seq_bytes, output malformed,
                  input ready);
  modport sink (input valid, input code_point, input seq_bytes, input malformed,
                output ready);
endinterface

/* rtl/utf8_stream_decoder_unit.sv */
// UTF-8 stream decoder: one byte per transfer in, one code point out per completed sequence.
// Takes one byte per clock cycle sustained while the output is not stalled. Each accepted
// byte lands in an input register; when the output is free, the step logic updates the
// sequence state and loads the result register with the code point that the byte completes.
// Lead bytes of 2 to 6 bytes set the sequence length; the following bytes are taken as
// trailing bytes without a check. A stray continuation byte or 0xFE/0xFF comes out alone
// with its byte value and malformed set. Back-pressure on the output stalls both stages.
module utf8_stream_decoder_unit (
  input logic         clk,
  input logic         rst,
  u8d_byte_if.sink    bytes,
  u8d_code_if.source  codes
);

  logic                       s1_valid;
  logic [u8d_pkg::ByteW-1:0] s1_byte;
  logic                       out_free;
  logic                       s1_adv;
  u8d_pkg::state_t            state;
  u8d_pkg::state_t            state_next;
  u8d_pkg::result_t           result;
  u8d_pkg::result_t           res_reg;

  assign out_free    = !res_reg.valid || codes.ready;
  assign s1_adv      = s1_valid && out_free;
  assign bytes.ready = !s1_valid || out_free;

  u8d_step step (
    .state      (state),
    .in_byte    (s1_byte),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (bytes.ready) begin
      s1_valid <= bytes.valid;
    end
    if (bytes.ready && bytes.valid) begin
      s1_byte <= bytes.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= '0;
      res_reg.valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        state <= state_next;
      end
      if (out_free) begin
        res_reg.valid <= s1_adv && result.valid;
      end
    end
    if (s1_adv && result.valid) begin
      res_reg.code_point <= result.code_point;
      res_reg.seq_bytes  <= result.seq_bytes;
      res_reg.malformed  <= result.malformed;
    end
  end

  assign codes.valid      = res_reg.valid;
  assign codes.code_point = res_reg.code_point;
  assign codes.seq_bytes  = res_reg.seq_bytes;
  assign codes.malformed  = res_reg.malformed;

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    res_reg.valid |-> (res_reg.seq_bytes != '0 && res_reg.seq_bytes <= u8d_pkg::MaxLen))
    else $error("seq_bytes out of range");

  a_malformed_single: assert property (@(posedge clk) disable iff (rst)
    (res_reg.valid && res_reg.malformed) |-> res_reg.seq_bytes == u8d_pkg::OneByte)
    else $error("malformed result spans more than one byte");

  a_left_below_len: assert property (@(posedge clk) disable iff (rst)
    state.bytes_left != '0 |-> state.bytes_left < state.sequence_length)
    else $error("bytes_left not below sequence_length");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (codes.valid && !codes.ready) |=> codes.valid && $stable(res_reg.code_point))
    else $error("pending result lost");

endmodule

/* rtl/u8d_step.sv */
// Step logic: next decoder state and optional result for one byte.
module u8d_step (
  input  u8d_pkg::state_t            state,
  input  logic [u8d_pkg::ByteW-1:0] in_byte,
  output u8d_pkg::state_t            state_next,
  output u8d_pkg::result_t           result
);

  logic [u8d_pkg::LenW-1:0]  lead_n;
  logic [u8d_pkg::ByteW-1:0] lead_mask;
  logic [u8d_pkg::CpW-1:0]   gathered;
  logic [u8d_pkg::LenW-1:0]  left_dec;

  always_comb begin
    priority casez (in_byte)
      8'b110?????: lead_n = 3'd2;
      8'b1110????: lead_n = 3'd3;
      8'b11110???: lead_n = 3'd4;
      8'b111110??: lead_n = 3'd5;
      8'b1111110?: lead_n = u8d_pkg::MaxLen;
      default:     lead_n = '0;
    endcase
  end

  assign lead_mask = u8d_pkg::PayloadMask >> lead_n;
  assign gathered  = {state.partial_value[u8d_pkg::CpW-u8d_pkg::ContW-1:0],
                      in_byte[u8d_pkg::ContW-1:0] & u8d_pkg::ContMask[u8d_pkg::ContW-1:0]};
  assign left_dec  = state.bytes_left - u8d_pkg::OneByte;

  always_comb begin
    state_next        = state;
    result.valid      = 1'b0;
    result.code_point = {{(u8d_pkg::CpW-u8d_pkg::ByteW){1'b0}}, in_byte};
    result.seq_bytes  = u8d_pkg::OneByte;
    result.malformed  = 1'b0;
    if (state.bytes_left != '0) begin
      state_next.partial_value = gathered;
      state_next.bytes_left    = left_dec;
      if (left_dec == '0) begin
        result.valid      = 1'b1;
        result.code_point = gathered;
        result.seq_bytes  = state.sequence_length;
      end
    end else if ((in_byte & u8d_pkg::AsciiBit) == '0) begin
      result.valid = 1'b1;
    end else if (lead_n == '0) begin
      result.valid     = 1'b1;
      result.malformed = 1'b1;
    end else begin
      state_next.partial_value   = {{(u8d_pkg::CpW-u8d_pkg::ByteW){1'b0}},
                                    in_byte & lead_mask};
      state_next.bytes_left      = lead_n - u8d_pkg::OneByte;
      state_next.sequence_length = lead_n;
    end
  end

endmodule

/* test/tb.sv */
// Testbench for utf8_stream_decoder_unit: directed and random byte streams checked against a predictor.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned ByteW     = u8d_pkg::ByteW;
  localparam int unsigned CpW       = u8d_pkg::CpW;
  localparam int unsigned LenW      = u8d_pkg::LenW;
  localparam int unsigned MinLead   = 2;
  localparam int unsigned RandBytes = 2000;
  localparam int unsigned HoldOff   = 300;
  localparam int unsigned Settle    = 10;
  localparam int unsigned Limit     = 400000;

  typedef struct {
    logic [CpW-1:0]  code_point;
    logic [LenW-1:0] seq_bytes;
    logic            malformed;
  } code_rec_t;

  class code_point_predictor;
    logic [CpW-1:0]  partial;
    logic [LenW-1:0] left;
    logic [LenW-1:0] seq_len;
    code_rec_t       awaited_codes[$];
    int              errors;

    function new();
      partial = '0;
      left    = '0;
      seq_len = '0;
      errors  = 0;
    endfunction

    function int pending();
      return awaited_codes.size();
    endfunction

    function void push_code(logic [CpW-1:0] cp, logic [LenW-1:0] len, logic bad);
      code_rec_t rec;
      rec.code_point = cp;
      rec.seq_bytes  = len;
      rec.malformed  = bad;
      awaited_codes.insert(awaited_codes.size(), rec);
    endfunction

    function void note_byte(logic [ByteW-1:0] b);
      int unsigned ones;
      if (left != 0) begin
        partial = (partial << u8d_pkg::ContW) | CpW'(b & u8d_pkg::ContMask);
        left    = left - 1'b1;
        if (left == 0) push_code(partial, seq_len, 1'b0);
        return;
      end
      if ((b & u8d_pkg::AsciiBit) == 0) begin
        push_code(CpW'(b), u8d_pkg::OneByte, 1'b0);
        return;
      end
      ones = 0;
      while (ones < ByteW && b[ByteW-1-ones]) ones++;
      if (ones < MinLead || ones > u8d_pkg::MaxLen) begin
        push_code(CpW'(b), u8d_pkg::OneByte, 1'b1);
        return;
      end
      partial = CpW'(b & (u8d_pkg::PayloadMask >> ones));
      left    = LenW'(ones - 1);
      seq_len = LenW'(ones);
    endfunction

    function void check_code(logic [CpW-1:0] cp, logic [LenW-1:0] len, logic bad);
      code_rec_t rec;
      if (awaited_codes.size() == 0) begin
        $error("unexpected transfer: code_point %h seq_bytes %0d malformed %0b", cp, len, bad);
        errors++;
        return;
      end
      rec = awaited_codes.pop_front();
      if (cp !== rec.code_point) begin
        $error("code_point: expected %h, got %h", rec.code_point, cp);
        errors++;
      end
      if (len !== rec.seq_bytes) begin
        $error("seq_bytes: expected %0d, got %0d", rec.seq_bytes, len);
        errors++;
      end
      if (bad !== rec.malformed) begin
        $error("malformed: expected %0b, got %0b", rec.malformed, bad);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  u8d_byte_if byte_ch ();
  u8d_code_if code_ch ();

  utf8_stream_decoder_unit u_top (
    .clk   (clk),
    .rst   (rst),
    .bytes (byte_ch),
    .codes (code_ch)
  );

  code_point_predictor decoder_model;
  bit                  hold_off_req;
  bit                  offering;
  int                  sent;
  int                  burst_left;
  int                  cycles;

  logic [ByteW-1:0] directed_bytes[$] = '{
    8'h00, 8'h7f, 8'h80, 8'hbf, 8'hfe, 8'hff,
    8'hc2, 8'ha9,
    8'he0, 8'h80, 8'h80,
    8'hf0, 8'h41, 8'hff, 8'h00,
    8'hf8, 8'h88, 8'h80, 8'h80, 8'h80,
    8'hfd, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && code_ch.valid && code_ch.ready)
      decoder_model.check_code(code_ch.code_point, code_ch.seq_bytes, code_ch.malformed);
  end

  initial begin
    int mode;
    int span;
    logic [15:0] pat;
    code_ch.ready = 1'b0;
    mode = 0;
    span = 0;
    pat  = '0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        code_ch.ready <= 1'b0;
        repeat (HoldOff) @(posedge clk);
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(16, 96);
          pat  = 16'($urandom);
        end
        span--;
        case (mode)
          0: code_ch.ready <= 1'b1;
          1: code_ch.ready <= ($urandom_range(0, 3) != 0);
          2: begin
            code_ch.ready <= pat[0];
            pat = {pat[0], pat[15:1]};
          end
          default: code_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic new_burst();
    burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
  endtask

  task automatic push_byte(input logic [ByteW-1:0] b);
    int gap;
    byte_ch.valid   <= 1'b1;
    byte_ch.in_byte <= b;
    offering = 1'b1;
    do @(posedge clk); while (!byte_ch.ready);
    decoder_model.note_byte(b);
    sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        byte_ch.valid <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk);
      end
      new_burst();
    end
  endtask

  task automatic send_sequence(input int n);
    logic [ByteW-1:0] lead;
    int i;
    if (n == 1) begin
      push_byte(ByteW'($urandom_range(0, 127)));
    end else begin
      lead = (8'hff << (8 - n)) | (ByteW'($urandom) & (u8d_pkg::PayloadMask >> n));
      push_byte(lead);
      for (i = 1; i < n; i++) begin
        if ($urandom_range(0, 7) == 0) push_byte(ByteW'($urandom));
        else push_byte(u8d_pkg::AsciiBit | (ByteW'($urandom) & u8d_pkg::ContMask));
      end
    end
  endtask

  task automatic drain_codes();
    if (offering) begin
      byte_ch.valid <= 1'b0;
      offering = 1'b0;
    end
    while (decoder_model.pending() != 0) @(posedge clk);
  endtask

  initial begin
    bit held;
    bit drained;
    decoder_model   = new();
    rst             = 1'b1;
    byte_ch.valid   = 1'b0;
    byte_ch.in_byte = '0;
    hold_off_req    = 1'b0;
    offering        = 1'b0;
    sent            = 0;
    cycles          = 0;
    held            = 1'b0;
    drained         = 1'b0;
    new_burst();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_bytes[i]) push_byte(directed_bytes[i]);

    while (sent < RandBytes) begin
      if (!held && sent >= 600) begin
        hold_off_req = 1'b1;
        held = 1'b1;
      end
      if (!drained && sent >= 1300) begin
        drain_codes();
        drained = 1'b1;
      end
      if ($urandom_range(0, 3) != 0) send_sequence($urandom_range(1, u8d_pkg::MaxLen));
      else push_byte(ByteW'($urandom));
    end

    drain_codes();
    repeat (Settle) @(posedge clk);
    if (decoder_model.errors == 0 && decoder_model.pending() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

/* utf8_stream_decoder_unit.f */
rtl/u8d_pkg.sv
rtl/u8d_ifs.sv
rtl/u8d_step.sv
rtl/utf8_stream_decoder_unit.sv
test/tb.sv
